// File: rtl/fjis_pkg.sv
package fjis_pkg;

  // number formats
  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int SLOT_W    = 7;
  localparam int REC_WORDS = 80;
  localparam int RAM_DEPTH = 128;
  localparam int ACC_W     = WORD_W + 4;
  localparam int PC_W      = 5;
  localparam int EM_W      = 5;

  typedef logic [SLOT_W-1:0] addr_t;

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_WARM  = 2'd1;
  localparam logic [1:0] REQ_SOLVE = 2'd2;

  // record slot map
  localparam addr_t S_V1  = 7'd0;
  localparam addr_t S_W1  = 7'd3;
  localparam addr_t S_V2  = 7'd6;
  localparam addr_t S_W2  = 7'd9;
  localparam addr_t S_R1  = 7'd12;
  localparam addr_t S_R2  = 7'd15;
  localparam addr_t S_IM1 = 7'd18;
  localparam addr_t S_IM2 = 7'd19;
  localparam addr_t S_II1 = 7'd20;
  localparam addr_t S_II2 = 7'd29;
  localparam addr_t S_KT  = 7'd38;
  localparam addr_t S_KR  = 7'd47;
  localparam addr_t S_BT  = 7'd56;
  localparam addr_t S_BR  = 7'd59;
  localparam addr_t S_LL1 = 7'd62;
  localparam addr_t S_AL1 = 7'd65;
  localparam addr_t S_LL2 = 7'd68;
  localparam addr_t S_AL2 = 7'd71;
  localparam addr_t S_PT  = 7'd74;
  localparam addr_t S_PR  = 7'd77;
  localparam addr_t S_REC = 7'd80;

  // scratch words above the record
  localparam addr_t T_F   = 7'd80;
  localparam addr_t T_T   = 7'd81;
  localparam addr_t T_NP  = 7'd84;
  localparam addr_t T_CA  = 7'd87;
  localparam addr_t T_A1  = 7'd90;
  localparam addr_t T_A2  = 7'd93;
  localparam addr_t T_C1  = 7'd84;
  localparam addr_t T_C2  = 7'd87;
  localparam addr_t T_JV  = 7'd90;
  localparam addr_t T_NJ  = 7'd93;
  localparam addr_t T_U   = 7'd96;
  localparam addr_t T_DL  = 7'd99;
  localparam addr_t T_ND  = 7'd102;
  localparam addr_t T_X1  = 7'd105;
  localparam addr_t T_NW1 = 7'd108;
  localparam addr_t T_X2  = 7'd111;
  localparam addr_t T_NX2 = 7'd114;
  localparam addr_t T_NW2 = 7'd117;
  localparam addr_t T_JR  = 7'd120;
  localparam addr_t T_NJR = 7'd123;
  localparam addr_t T_U2  = 7'd84;
  localparam addr_t T_DR  = 7'd87;
  localparam addr_t T_NDR = 7'd90;

  // vector macro operations
  typedef enum logic [2:0] {
    MK_NEG, MK_ADD, MK_SUB, MK_CROSS, MK_MVEC, MK_LIN, MK_ANG, MK_JV
  } mkind_t;

  typedef struct packed {
    mkind_t kind;
    logic   last;
    addr_t  x0;
    addr_t  x1;
    addr_t  x2;
    addr_t  x3;
    addr_t  d;
  } macro_t;

  // one step of the shared unit
  typedef struct packed {
    logic  mul;
    logic  neg;
    logic  clr;
    logic  wr;
    addr_t a;
    addr_t b;
    addr_t d;
  } uop_t;

  typedef struct packed {
    logic lat_a;
    logic do_mul;
    logic do_acc;
    logic use_prod;
    logic neg;
    logic clr;
  } mac_ctl_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [SLOT_W-1:0]        word_slot;
    logic signed [WORD_W-1:0] word_value;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]        out_slot;
    logic signed [WORD_W-1:0] out_value;
    logic                     last_word;
  } out_t;

  localparam logic [PC_W-1:0] PC_SOLVE = 5'd0;
  localparam logic [PC_W-1:0] PC_WARM  = 5'd23;

  function automatic macro_t mk(input mkind_t k, input logic l, input addr_t x0,
                                input addr_t x1, input addr_t x2, input addr_t x3,
                                input addr_t d);
    macro_t m;
    m.kind = k;
    m.last = l;
    m.x0   = x0;
    m.x1   = x1;
    m.x2   = x2;
    m.x3   = x3;
    m.d    = d;
    return m;
  endfunction

  // macro program: solve, then warm start
  function automatic macro_t macro_rom(input logic [PC_W-1:0] pc);
    macro_t m;
    case (pc)
      5'd0:  m = mk(MK_CROSS, 1'b0, S_W2,  S_R2,  S_V1,  S_V1,  T_C2);
      5'd1:  m = mk(MK_CROSS, 1'b0, S_W1,  S_R1,  S_V1,  S_V1,  T_C1);
      5'd2:  m = mk(MK_JV,    1'b0, S_V2,  T_C2,  S_V1,  T_C1,  T_JV);
      5'd3:  m = mk(MK_NEG,   1'b0, T_JV,  S_V1,  S_V1,  S_V1,  T_NJ);
      5'd4:  m = mk(MK_SUB,   1'b0, T_NJ,  S_BT,  S_V1,  S_V1,  T_U);
      5'd5:  m = mk(MK_MVEC,  1'b0, S_KT,  T_U,   S_V1,  S_V1,  T_DL);
      5'd6:  m = mk(MK_ADD,   1'b0, S_PT,  T_DL,  S_V1,  S_V1,  S_PT);
      5'd7:  m = mk(MK_NEG,   1'b0, T_DL,  S_V1,  S_V1,  S_V1,  T_ND);
      5'd8:  m = mk(MK_LIN,   1'b0, S_V1,  S_IM1, S_LL1, T_ND,  S_V1);
      5'd9:  m = mk(MK_CROSS, 1'b0, T_DL,  S_R1,  S_V1,  S_V1,  T_X1);
      5'd10: m = mk(MK_ANG,   1'b0, S_W1,  S_AL1, S_II1, T_X1,  T_NW1);
      5'd11: m = mk(MK_LIN,   1'b0, S_V2,  S_IM2, S_LL2, T_DL,  S_V2);
      5'd12: m = mk(MK_CROSS, 1'b0, T_DL,  S_R2,  S_V1,  S_V1,  T_X2);
      5'd13: m = mk(MK_NEG,   1'b0, T_X2,  S_V1,  S_V1,  S_V1,  T_NX2);
      5'd14: m = mk(MK_ANG,   1'b0, S_W2,  S_AL2, S_II2, T_NX2, T_NW2);
      5'd15: m = mk(MK_SUB,   1'b0, T_NW2, T_NW1, S_V1,  S_V1,  T_JR);
      5'd16: m = mk(MK_NEG,   1'b0, T_JR,  S_V1,  S_V1,  S_V1,  T_NJR);
      5'd17: m = mk(MK_SUB,   1'b0, T_NJR, S_BR,  S_V1,  S_V1,  T_U2);
      5'd18: m = mk(MK_MVEC,  1'b0, S_KR,  T_U2,  S_V1,  S_V1,  T_DR);
      5'd19: m = mk(MK_ADD,   1'b0, S_PR,  T_DR,  S_V1,  S_V1,  S_PR);
      5'd20: m = mk(MK_NEG,   1'b0, T_DR,  S_V1,  S_V1,  S_V1,  T_NDR);
      5'd21: m = mk(MK_ANG,   1'b0, T_NW1, S_AL1, S_II1, T_NDR, S_W1);
      5'd22: m = mk(MK_ANG,   1'b1, T_NW2, S_AL2, S_II2, T_DR,  S_W2);
      5'd23: m = mk(MK_NEG,   1'b0, S_PT,  S_V1,  S_V1,  S_V1,  T_NP);
      5'd24: m = mk(MK_CROSS, 1'b0, S_PT,  S_R1,  S_V1,  S_V1,  T_CA);
      5'd25: m = mk(MK_SUB,   1'b0, T_CA,  S_PR,  S_V1,  S_V1,  T_A1);
      5'd26: m = mk(MK_CROSS, 1'b0, T_NP,  S_R2,  S_V1,  S_V1,  T_CA);
      5'd27: m = mk(MK_ADD,   1'b0, T_CA,  S_PR,  S_V1,  S_V1,  T_A2);
      5'd28: m = mk(MK_LIN,   1'b0, S_V1,  S_IM1, S_LL1, T_NP,  S_V1);
      5'd29: m = mk(MK_ANG,   1'b0, S_W1,  S_AL1, S_II1, T_A1,  S_W1);
      5'd30: m = mk(MK_LIN,   1'b0, S_V2,  S_IM2, S_LL2, S_PT,  S_V2);
      5'd31: m = mk(MK_ANG,   1'b1, S_W2,  S_AL2, S_II2, T_A2,  S_W2);
      default: m = mk(MK_NEG, 1'b1, S_V1,  S_V1,  S_V1,  S_V1,  T_F);
    endcase
    return m;
  endfunction

  // clamp to the signed word range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] x);
    logic signed [63:0] hi_lim;
    logic signed [63:0] lo_lim;
    hi_lim = 64'sd2147483647;
    lo_lim = -64'sd2147483648;
    if (x > hi_lim) return hi_lim[WORD_W-1:0];
    if (x < lo_lim) return lo_lim[WORD_W-1:0];
    return x[WORD_W-1:0];
  endfunction

endpackage

// File: rtl/fixed_joint_impulse_solver.sv
// load: written into the record while idle, no result; the block stays ready
// warm start: runs from start to the last of 12 results
// solve: runs from start to the last of 18 results
// one item at a time, through the single shared multiply-accumulate unit and
// the one record read port (mul step RA RB MUL ACC, add step RA ACC, result EMA EMD)
// synchronous active-low reset idles the sequencer; the record is not cleared
module fixed_joint_impulse_solver (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  fjis_pkg::in_t  in_item,
  output logic           busy,
  output logic           out_valid,
  output fjis_pkg::out_t out_item
);

  fjis_pkg::mac_ctl_t                 mac_ctl;
  logic signed [fjis_pkg::WORD_W-1:0] wval;
  logic [fjis_pkg::WORD_W-1:0]        rdata;
  logic                               ram_we;
  fjis_pkg::addr_t                    ram_waddr;
  logic [fjis_pkg::WORD_W-1:0]        ram_wdata;
  fjis_pkg::addr_t                    ram_raddr;

  // joint record and scratch words
  fjis_ram #(
    .WIDTH(fjis_pkg::WORD_W),
    .DEPTH(fjis_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // shared multiply-accumulate unit
  fjis_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .rdata (rdata),
    .wval  (wval)
  );

  // sequencer
  fjis_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mac_ctl   (mac_ctl),
    .wval      (wval),
    .rdata     (rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr)
  );

endmodule

// File: rtl/fjis_ram.sv
module fjis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fjis_mac.sv
module fjis_mac (
  input  logic                              clk,
  input  fjis_pkg::mac_ctl_t                ctl,
  input  logic signed [fjis_pkg::WORD_W-1:0] rdata,
  output logic signed [fjis_pkg::WORD_W-1:0] wval
);

  logic signed [fjis_pkg::WORD_W-1:0] a_r;
  logic signed [63:0]                 prod_r;
  logic signed [fjis_pkg::ACC_W-1:0]  acc_r;
  logic signed [63:0]                 shifted;
  logic signed [fjis_pkg::WORD_W-1:0] term;
  logic signed [fjis_pkg::ACC_W-1:0]  term_x;
  logic signed [fjis_pkg::ACC_W-1:0]  base;
  logic signed [fjis_pkg::ACC_W-1:0]  acc_nxt;

  // operand latch, multiplier and accumulator registers
  always_ff @(posedge clk) begin
    if (ctl.lat_a) begin
      a_r <= rdata;
    end
    if (ctl.do_mul) begin
      prod_r <= a_r * rdata;
    end
    if (ctl.do_acc) begin
      acc_r <= acc_nxt;
    end
  end

  // truncate product to the fixed-point grid and clamp it to a word, then accumulate exactly
  always_comb begin
    shifted = prod_r >>> fjis_pkg::FRAC_BITS;
    term    = ctl.use_prod ? fjis_pkg::sat_word(shifted) : rdata;
    term_x  = {{(fjis_pkg::ACC_W-fjis_pkg::WORD_W){term[fjis_pkg::WORD_W-1]}}, term};
    base    = ctl.clr ? '0 : acc_r;
    acc_nxt = ctl.neg ? base - term_x : base + term_x;
    wval    = fjis_pkg::sat_word({{(64-fjis_pkg::ACC_W){acc_nxt[fjis_pkg::ACC_W-1]}}, acc_nxt});
  end

endmodule

// File: rtl/fjis_seq.sv
module fjis_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  fjis_pkg::in_t                     in_item,
  output logic                              busy,
  output logic                              out_valid,
  output fjis_pkg::out_t                    out_item,
  output fjis_pkg::mac_ctl_t                mac_ctl,
  input  logic signed [fjis_pkg::WORD_W-1:0] wval,
  input  logic [fjis_pkg::WORD_W-1:0]       rdata,
  output logic                              ram_we,
  output fjis_pkg::addr_t                   ram_waddr,
  output logic [fjis_pkg::WORD_W-1:0]       ram_wdata,
  output fjis_pkg::addr_t                   ram_raddr
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RA   = 7'b0000010,
    ST_RB   = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_ACC  = 7'b0010000,
    ST_EMA  = 7'b0100000,
    ST_EMD  = 7'b1000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [fjis_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic                        part_r, part_nxt;
  logic [1:0]                  hi_r, hi_nxt;
  logic [1:0]                  lo_r, lo_nxt;
  logic                        solve_r, solve_nxt;
  logic [fjis_pkg::EM_W-1:0]   em_r, em_nxt;
  logic                        out_valid_r;
  fjis_pkg::out_t              out_item_r;

  fjis_pkg::macro_t            mac;
  fjis_pkg::uop_t              uop;
  logic [1:0]                  lo_max;
  logic                        mac_done;
  fjis_pkg::addr_t             hi7, lo7, row3, rot1, rot2;
  fjis_pkg::addr_t             em_slot;
  logic                        em_last;
  logic                        load_go;

  assign mac = fjis_pkg::macro_rom(pc_r);
  assign hi7 = {5'd0, hi_r};
  assign lo7 = {5'd0, lo_r};
  assign row3 = {4'd0, hi_r, 1'b0} + hi7;

  // cyclic component indices for cross products
  always_comb begin
    case (hi_r)
      2'd0:    begin rot1 = 7'd1; rot2 = 7'd2; end
      2'd1:    begin rot1 = 7'd2; rot2 = 7'd0; end
      default: begin rot1 = 7'd0; rot2 = 7'd1; end
    endcase
  end

  // steps per component of each macro
  always_comb begin
    unique case (mac.kind) inside
      fjis_pkg::MK_NEG:                     lo_max = 2'd0;
      fjis_pkg::MK_ADD, fjis_pkg::MK_SUB,
      fjis_pkg::MK_CROSS:                   lo_max = 2'd1;
      fjis_pkg::MK_MVEC, fjis_pkg::MK_LIN:  lo_max = 2'd2;
      fjis_pkg::MK_ANG:                     lo_max = part_r ? 2'd1 : 2'd2;
      fjis_pkg::MK_JV:                      lo_max = 2'd3;
      default:                              lo_max = 2'd0;
    endcase
  end

  assign mac_done = (lo_r == lo_max) && (hi_r == 2'd2) &&
                    !((mac.kind == fjis_pkg::MK_ANG) && !part_r);

  // expand the current macro step into one operation of the shared unit
  always_comb begin
    uop = '0;
    unique case (mac.kind) inside
      fjis_pkg::MK_NEG: begin
        uop.a = mac.x0 + hi7; uop.neg = 1'b1; uop.clr = 1'b1;
        uop.wr = 1'b1; uop.d = mac.d + hi7;
      end
      fjis_pkg::MK_ADD, fjis_pkg::MK_SUB: begin
        if (lo_r == 2'd0) begin
          uop.a = mac.x0 + hi7; uop.clr = 1'b1;
        end else begin
          uop.a = mac.x1 + hi7; uop.neg = (mac.kind == fjis_pkg::MK_SUB);
          uop.wr = 1'b1; uop.d = mac.d + hi7;
        end
      end
      fjis_pkg::MK_CROSS: begin
        uop.mul = 1'b1;
        if (lo_r == 2'd0) begin
          uop.a = mac.x0 + rot1; uop.b = mac.x1 + rot2; uop.clr = 1'b1;
        end else begin
          uop.a = mac.x0 + rot2; uop.b = mac.x1 + rot1; uop.neg = 1'b1;
          uop.wr = 1'b1; uop.d = mac.d + hi7;
        end
      end
      fjis_pkg::MK_MVEC: begin
        uop.mul = 1'b1; uop.a = mac.x0 + row3 + lo7; uop.b = mac.x1 + lo7;
        uop.clr = (lo_r == 2'd0); uop.wr = (lo_r == 2'd2); uop.d = mac.d + hi7;
      end
      fjis_pkg::MK_LIN: begin
        if (lo_r == 2'd0) begin
          uop.mul = 1'b1; uop.a = mac.x1; uop.b = mac.x2 + hi7;
          uop.clr = 1'b1; uop.wr = 1'b1; uop.d = fjis_pkg::T_F;
        end else if (lo_r == 2'd1) begin
          uop.a = mac.x0 + hi7; uop.clr = 1'b1;
        end else begin
          uop.mul = 1'b1; uop.a = fjis_pkg::T_F; uop.b = mac.x3 + hi7;
          uop.wr = 1'b1; uop.d = mac.d + hi7;
        end
      end
      fjis_pkg::MK_ANG: begin
        if (!part_r) begin
          uop.mul = 1'b1; uop.a = mac.x2 + row3 + lo7; uop.b = mac.x3 + lo7;
          uop.clr = (lo_r == 2'd0); uop.wr = (lo_r == 2'd2);
          uop.d = fjis_pkg::T_T + hi7;
        end else if (lo_r == 2'd0) begin
          uop.a = mac.x0 + hi7; uop.clr = 1'b1;
        end else begin
          uop.mul = 1'b1; uop.a = mac.x1 + hi7; uop.b = fjis_pkg::T_T + hi7;
          uop.wr = 1'b1; uop.d = mac.d + hi7;
        end
      end
      fjis_pkg::MK_JV: begin
        case (lo_r)
          2'd0:    begin uop.a = mac.x0 + hi7; uop.clr = 1'b1; end
          2'd1:    uop.a = mac.x1 + hi7;
          2'd2:    begin uop.a = mac.x2 + hi7; uop.neg = 1'b1; end
          default: begin
            uop.a = mac.x3 + hi7; uop.neg = 1'b1; uop.wr = 1'b1; uop.d = mac.d + hi7;
          end
        endcase
      end
      default: uop = '0;
    endcase
  end

  // emitted slots: velocities, then impulses on solve
  assign em_slot = (em_r < 5'd12) ? {2'd0, em_r} : {2'd0, em_r} + 7'd62;
  assign em_last = solve_r ? (em_r == 5'd17) : (em_r == 5'd11);
  assign load_go = (state_r == ST_IDLE) && start &&
                   (in_item.req_type == fjis_pkg::REQ_LOAD) &&
                   (in_item.word_slot < fjis_pkg::S_REC);

  // record port and unit control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = uop.d;
    ram_wdata = wval;
    if (load_go) begin
      ram_we    = 1'b1;
      ram_waddr = in_item.word_slot;
      ram_wdata = in_item.word_value;
    end else if ((state_r == ST_ACC) && uop.wr) begin
      ram_we = 1'b1;
    end
    unique case (state_r)
      ST_RB:   ram_raddr = uop.b;
      ST_EMA:  ram_raddr = em_slot;
      default: ram_raddr = uop.a;
    endcase
    mac_ctl.lat_a    = (state_r == ST_RB);
    mac_ctl.do_mul   = (state_r == ST_MUL);
    mac_ctl.do_acc   = (state_r == ST_ACC);
    mac_ctl.use_prod = uop.mul;
    mac_ctl.neg      = uop.neg;
    mac_ctl.clr      = uop.clr;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    part_nxt  = part_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    solve_nxt = solve_r;
    em_nxt    = em_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          part_nxt = 1'b0;
          hi_nxt   = 2'd0;
          lo_nxt   = 2'd0;
          case (in_item.req_type)
            fjis_pkg::REQ_WARM: begin
              pc_nxt = fjis_pkg::PC_WARM; solve_nxt = 1'b0; state_nxt = ST_RA;
            end
            fjis_pkg::REQ_SOLVE: begin
              pc_nxt = fjis_pkg::PC_SOLVE; solve_nxt = 1'b1; state_nxt = ST_RA;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RA:  state_nxt = uop.mul ? ST_RB : ST_ACC;
      ST_RB:  state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        state_nxt = ST_RA;
        if (lo_r != lo_max) begin
          lo_nxt = lo_r + 2'd1;
        end else begin
          lo_nxt = 2'd0;
          if (hi_r != 2'd2) begin
            hi_nxt = hi_r + 2'd1;
          end else if (!mac_done) begin
            hi_nxt   = 2'd0;
            part_nxt = 1'b1;
          end else begin
            hi_nxt   = 2'd0;
            part_nxt = 1'b0;
            if (mac.last) begin
              em_nxt    = '0;
              state_nxt = ST_EMA;
            end else begin
              pc_nxt = pc_r + 1'b1;
            end
          end
        end
      end
      ST_EMA: state_nxt = ST_EMD;
      ST_EMD: begin
        if (em_last) begin
          state_nxt = ST_IDLE;
        end else begin
          em_nxt    = em_r + 1'b1;
          state_nxt = ST_EMA;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      part_r      <= 1'b0;
      hi_r        <= '0;
      lo_r        <= '0;
      solve_r     <= 1'b0;
      em_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      part_r      <= part_nxt;
      hi_r        <= hi_nxt;
      lo_r        <= lo_nxt;
      solve_r     <= solve_nxt;
      em_r        <= em_nxt;
      out_valid_r <= (state_r == ST_EMD);
    end
  end

  // result register, one transfer per strobe
  always_ff @(posedge clk) begin
    if (state_r == ST_EMD) begin
      out_item_r.out_slot  <= em_slot;
      out_item_r.out_value <= rdata;
      out_item_r.last_word <= em_last;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/fjis_checker.sv
module fjis_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input fjis_pkg::in_t  in_item,
  input logic           busy,
  input logic           out_valid,
  input fjis_pkg::out_t out_item
);

  // a load never makes the block busy
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.req_type == fjis_pkg::REQ_LOAD) |=> !busy)
    else $error("load made the block busy");

  // warm start and solve occupy the block
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && ((in_item.req_type == fjis_pkg::REQ_WARM) ||
                       (in_item.req_type == fjis_pkg::REQ_SOLVE)) |=> busy)
    else $error("run request not taken");

  // a result strobe is never directly followed by another
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back to back result strobes");

  // after the final result the block is idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_word |-> !busy)
    else $error("busy after final result");

  // no result appears while idle unless it closes a run
  a_out_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_word |-> busy)
    else $error("result outside a run");

endmodule

bind fixed_joint_impulse_solver fjis_checker u_chk (.*);
